// File: src/btlp_pkg.sv
// Package for the branch trace line parser: parse phases, state and result
// structs, character constants and byte classification helpers.
// No dependencies.
package btlp_pkg;

    // character codes used by the line format
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF_HEX = 8'h66;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_N     = 8'h4E;

    // field widths
    localparam int ADDR_W  = 64;
    localparam int COUNT_W = 32;
    localparam int DIGIT_W = 4;

    // parse phase within one line
    typedef enum logic [2:0] {
        PH_START,
        PH_COMMENT,
        PH_ZERO,
        PH_HEX,
        PH_GAP,
        PH_OUTCOME,
        PH_TAIL
    } t_phase;

    // per-line parse state
    typedef struct packed {
        t_phase              phase;
        logic [ADDR_W-1:0]   acc;
        logic                digit_seen;
        logic                bad;
        logic                taken;
    } t_line_state;

    // one result transaction
    typedef struct packed {
        logic                valid;
        logic [ADDR_W-1:0]   address;
        logic                taken;
        logic                malformed;
        logic [COUNT_W-1:0]  index;
    } t_result;

    // whitespace: space, tab, cr, vt, ff
    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) ||
               (c == CH_VT) || (c == CH_FF);
    endfunction

    // hex digit decode: msb is the digit-valid flag
    function automatic logic [DIGIT_W:0] hex_digit(input logic [7:0] c);
        logic [7:0] v;
        v = 8'h00;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            v = c - CH_ZERO;
            return {1'b1, v[DIGIT_W-1:0]};
        end
        if (c >= CH_LA && c <= CH_LF_HEX) begin
            v = c - CH_LA + 8'd10;
            return {1'b1, v[DIGIT_W-1:0]};
        end
        if (c >= CH_UA && c <= CH_UF) begin
            v = c - CH_UA + 8'd10;
            return {1'b1, v[DIGIT_W-1:0]};
        end
        return '0;
    endfunction

    // reset value of the per-line state
    localparam t_line_state LINE_START = '{
        phase: PH_START, acc: '0, digit_seen: 1'b0, bad: 1'b0, taken: 1'b0
    };

endpackage

// File: src/branch_trace_line_parser.sv
// Branch trace line parser: takes one byte per cycle while o_stall is low and
// gives address and outcome records or one malformed result. Depends on
// btlp_pkg, btlp_step. A result is registered: it is on the output in the
// cycle after the byte that closes its line is accepted. The byte rate is
// set by the single next-state step between the state registers and the
// result register. Stalls: o_stall is high while a held result sees i_stall,
// even for bytes that would give no result; otherwise no byte is ever stalled.
// Reset (synchronous, active low) returns to line start, count zero, running.
module branch_trace_line_parser (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [7:0]                        i_char_code,
    input  logic                              i_final_byte,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [btlp_pkg::ADDR_W-1:0]       o_branch_address,
    output logic                              o_taken,
    output logic                              o_malformed,
    output logic [btlp_pkg::COUNT_W-1:0]      o_line_index
);

    btlp_pkg::t_line_state          r_state, n_state;
    logic [btlp_pkg::COUNT_W-1:0]   r_line_count, n_line_count;
    logic                           r_halted, n_halted;
    btlp_pkg::t_result              step_result;
    logic                           r_out_valid;
    logic [btlp_pkg::ADDR_W-1:0]    r_out_address;
    logic                           r_out_taken;
    logic                           r_out_malformed;
    logic [btlp_pkg::COUNT_W-1:0]   r_out_index;
    logic                           in_accept;
    logic                           out_load;

    // next state for the current byte
    btlp_step u_step (
        .i_state      (r_state),
        .i_line_count (r_line_count),
        .i_halted     (r_halted),
        .i_char_code  (i_char_code),
        .i_final_byte (i_final_byte),
        .o_state      (n_state),
        .o_line_count (n_line_count),
        .o_halted     (n_halted),
        .o_result     (step_result)
    );

    // handshake
    assign o_stall   = r_out_valid && i_stall;
    assign in_accept = i_valid && !o_stall;
    assign out_load  = in_accept && step_result.valid;

    // parser state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= btlp_pkg::LINE_START;
            r_line_count <= '0;
            r_halted     <= 1'b0;
        end else if (in_accept) begin
            r_state      <= n_state;
            r_line_count <= n_line_count;
            r_halted     <= n_halted;
        end
    end

    // result register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_address   <= step_result.address;
            r_out_taken     <= step_result.taken;
            r_out_malformed <= step_result.malformed;
            r_out_index     <= step_result.index;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_branch_address = r_out_address;
    assign o_taken          = r_out_taken;
    assign o_malformed      = r_out_malformed;
    assign o_line_index     = r_out_index;

    // a malformed result always leaves the parser halted
    a_malformed_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_malformed |-> r_halted)
        else $error("malformed result without halt");

    // a good result cannot coexist with the halted state
    a_good_not_halted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_malformed |-> !r_halted)
        else $error("good result while halted");

    // once halted, no new transaction is produced
    a_halted_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted && !o_stall |=> !r_out_valid)
        else $error("result produced while halted");

    // line numbers are one-based
    a_index_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out_index != '0)
        else $error("zero line index in result");

endmodule

// File: src/btlp_step.sv
// Next-state logic for one byte of the branch trace line parser: phase
// update, hex shift-in, line close and result formation.
// Depends on btlp_pkg.
module btlp_step (
    input  btlp_pkg::t_line_state             i_state,
    input  logic [btlp_pkg::COUNT_W-1:0]      i_line_count,
    input  logic                              i_halted,
    input  logic [7:0]                        i_char_code,
    input  logic                              i_final_byte,
    output btlp_pkg::t_line_state             o_state,
    output logic [btlp_pkg::COUNT_W-1:0]      o_line_count,
    output logic                              o_halted,
    output btlp_pkg::t_result                 o_result
);

    btlp_pkg::t_line_state          s_take;
    logic                           ws;
    logic [btlp_pkg::DIGIT_W:0]     hv;
    logic                           is_lf;
    logic                           close;
    logic [btlp_pkg::COUNT_W-1:0]   count_inc;
    logic                           skip_line;
    logic                           good;

    // one byte through the line grammar
    always_comb begin
        s_take = i_state;
        ws     = btlp_pkg::is_space(i_char_code);
        hv     = btlp_pkg::hex_digit(i_char_code);
        if (!i_state.bad) begin
            unique case (i_state.phase)
                btlp_pkg::PH_START: begin
                    if (!ws) begin
                        if (i_char_code == btlp_pkg::CH_HASH) begin
                            s_take.phase = btlp_pkg::PH_COMMENT;
                        end else if (i_char_code == btlp_pkg::CH_ZERO) begin
                            s_take.phase = btlp_pkg::PH_ZERO;
                        end else begin
                            s_take.bad = 1'b1;
                        end
                    end
                end
                btlp_pkg::PH_COMMENT: begin
                end
                btlp_pkg::PH_ZERO: begin
                    if (i_char_code == btlp_pkg::CH_X) begin
                        s_take.phase = btlp_pkg::PH_HEX;
                    end else begin
                        s_take.bad = 1'b1;
                    end
                end
                btlp_pkg::PH_HEX: begin
                    if (ws) begin
                        if (i_state.digit_seen) begin
                            s_take.phase = btlp_pkg::PH_GAP;
                        end else begin
                            s_take.bad = 1'b1;
                        end
                    end else if (!hv[btlp_pkg::DIGIT_W] ||
                                 (i_state.acc[btlp_pkg::ADDR_W-1 -: btlp_pkg::DIGIT_W] != '0)) begin
                        // not a hex digit, or the shift would overflow
                        s_take.bad = 1'b1;
                    end else begin
                        s_take.acc = {i_state.acc[btlp_pkg::ADDR_W-btlp_pkg::DIGIT_W-1:0],
                                      hv[btlp_pkg::DIGIT_W-1:0]};
                        s_take.digit_seen = 1'b1;
                    end
                end
                btlp_pkg::PH_GAP: begin
                    if (!ws) begin
                        if (i_char_code == btlp_pkg::CH_T ||
                            i_char_code == btlp_pkg::CH_N) begin
                            s_take.taken = (i_char_code == btlp_pkg::CH_T);
                            s_take.phase = btlp_pkg::PH_OUTCOME;
                        end else begin
                            s_take.bad = 1'b1;
                        end
                    end
                end
                btlp_pkg::PH_OUTCOME, btlp_pkg::PH_TAIL: begin
                    if (ws) begin
                        s_take.phase = btlp_pkg::PH_TAIL;
                    end else begin
                        s_take.bad = 1'b1;
                    end
                end
                default: begin
                    s_take.bad = 1'b1;
                end
            endcase
        end
    end

    // line close and result
    always_comb begin
        is_lf     = (i_char_code == btlp_pkg::CH_LF);
        close     = is_lf || i_final_byte;
        count_inc = (&i_line_count) ? i_line_count
                                    : i_line_count + btlp_pkg::COUNT_W'(1);

        o_state      = is_lf ? i_state : s_take;
        o_line_count = i_line_count;
        o_halted     = i_halted;
        o_result     = '0;
        skip_line    = 1'b0;
        good         = 1'b0;

        if (i_halted) begin
            o_state = i_state;
        end else if (close) begin
            o_line_count = count_inc;
            skip_line = !o_state.bad && (o_state.phase == btlp_pkg::PH_START ||
                                         o_state.phase == btlp_pkg::PH_COMMENT);
            good = !o_state.bad && (o_state.phase == btlp_pkg::PH_OUTCOME ||
                                    o_state.phase == btlp_pkg::PH_TAIL);
            if (!skip_line) begin
                o_result.valid     = 1'b1;
                o_result.address   = good ? o_state.acc : '0;
                o_result.taken     = good && o_state.taken;
                o_result.malformed = !good;
                o_result.index     = count_inc;
                o_halted           = !good;
            end
            o_state = btlp_pkg::LINE_START;
        end
    end

endmodule
